// ===== design/idec_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the decimal integer field formatter
// no dependencies; used by every module of the block

package idec_pkg;

  // argument and digit row sizes
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned NUM_DIGITS = 20;   // 2^64 has 20 decimal digits
  localparam int unsigned NDIG_W     = 5;
  localparam int unsigned LEN_W      = 8;    // character counts and positions
  localparam int unsigned BIT_CNT_W  = 6;

  // conversion mode codes
  localparam logic MODE_SIGNED   = 1'b0;
  localparam logic MODE_UNSIGNED = 1'b1;

  // length modifier codes
  localparam logic [1:0] LSEL_INT   = 2'd0;
  localparam logic [1:0] LSEL_SHORT = 2'd1;
  localparam logic [1:0] LSEL_LONG  = 2'd2;

  // ascii characters
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // operation applied to every digit cell of the row
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_CONV,
    CELL_SHIFT
  } cell_op_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_SETUP,
    ST_EMIT
  } state_e;

  typedef logic [3:0] bcd_t;

endpackage

// ===== design/idec_digit_cell.sv =====
`timescale 1ns / 1ps
// one bcd digit cell: shift-and-add-3 step during conversion, move up when normalising or emitting
// depends on idec_pkg

module idec_digit_cell (
  input  logic               clk_i,
  input  idec_pkg::cell_op_e op_i,
  input  logic               carry_i,
  input  idec_pkg::bcd_t     digit_i,
  output logic               carry_o,
  output idec_pkg::bcd_t     digit_o
);

  idec_pkg::bcd_t digit_q, digit_d;
  idec_pkg::bcd_t adj;

  // add 3 when the digit would overflow after doubling
  assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
  assign carry_o = adj[3];
  assign digit_o = digit_q;

  // next digit value
  always_comb begin
    unique case (op_i)
      idec_pkg::CELL_CLEAR: digit_d = '0;
      idec_pkg::CELL_CONV:  digit_d = {adj[2:0], carry_i};
      idec_pkg::CELL_SHIFT: digit_d = digit_i;
      default:              digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

// ===== design/idec_digit_chain.sv =====
`timescale 1ns / 1ps
// row of bcd digit cells; binary bits enter at the bottom, digits leave at the top
// depends on idec_pkg and idec_digit_cell

module idec_digit_chain (
  input  logic               clk_i,
  input  idec_pkg::cell_op_e op_i,
  input  logic               bit_i,
  output idec_pkg::bcd_t     top_digit_o
);

  localparam int unsigned N = idec_pkg::NUM_DIGITS;

  logic           carry [N];
  idec_pkg::bcd_t digit [N];

  // cell 0 is the least significant digit
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic           cin;
    idec_pkg::bcd_t din;

    if (i == 0) begin : g_first
      assign cin = bit_i;
      assign din = '0;
    end else begin : g_rest
      assign cin = carry[i-1];
      assign din = digit[i-1];
    end

    idec_digit_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op_i),
      .carry_i (cin),
      .digit_i (din),
      .carry_o (carry[i]),
      .digit_o (digit[i])
    );
  end

  assign top_digit_o = digit[N-1];

endmodule

// ===== design/integer_decimal_field_formatter_unit.sv =====
`timescale 1ns / 1ps
// top level of the %d / %u field formatter: request capture, sequencer, output register
// depends on idec_pkg and idec_digit_chain
//
//  channel | handshake              | word
//  --------+------------------------+----------------------------------------------
//  in      | in_valid_i / in_ready_o | conversion request (value, mode, flags, ...)
//  out     | out_valid_o/out_ready_i | one ascii character_o with last_o
//
//  A request runs shift-and-add-3 in the digit row (one argument bit per cycle),
//  then removes leading zero digits one at a time up to a final check, takes a
//  setup step and emits its characters while the output register is free, at
//  most MaxFieldWidth characters.
//  One request is in flight at a time; in_ready_o rises once the final character
//  sits in the output register, or after setup for an empty field. A stalled output
//  stalls emission. Reset, asynchronous and active low, returns the sequencer to idle.

module integer_decimal_field_formatter_unit #(
  parameter int unsigned MaxFieldWidth = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [1:0]  length_sel_i,
  input  logic [63:0] value_i,
  input  logic        left_justify_i,
  input  logic        plus_sign_i,
  input  logic        space_sign_i,
  input  logic [5:0]  field_width_i,
  input  logic        precision_given_i,
  input  logic [5:0]  min_digits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  character_o,
  output logic        last_o
);

  localparam int unsigned LW = idec_pkg::LEN_W;
  localparam logic [LW-1:0] MaxLen = LW'(MaxFieldWidth);
  localparam logic [idec_pkg::NDIG_W-1:0] NumDigits = idec_pkg::NDIG_W'(idec_pkg::NUM_DIGITS);

  idec_pkg::state_e state_q, state_d;

  logic [idec_pkg::VALUE_W-1:0]   mag_q, mag_d;
  logic [idec_pkg::BIT_CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]                     sign_q, sign_d;
  logic                           has_sign_q, has_sign_d;
  logic                           left_q, left_d;
  logic [5:0]                     width_q, width_d;
  logic                           has_prec_q, has_prec_d;
  logic [5:0]                     prec_q, prec_d;
  logic [idec_pkg::NDIG_W-1:0]    ndig_q, ndig_d;
  logic [LW-1:0]                  b1_q, b1_d, b2_q, b2_d, b3_q, b3_d, b4_q, b4_d;
  logic [LW-1:0]                  n_q, n_d, k_q, k_d;
  logic                           out_valid_q, out_valid_d;
  logic [7:0]                     out_char_q, out_char_d;
  logic                           out_last_q, out_last_d;

  idec_pkg::cell_op_e cell_op;
  idec_pkg::bcd_t     top_digit;

  // argument after truncation and extension
  logic [63:0] ext_val;
  logic        neg;
  logic [63:0] in_mag;

  // field layout arithmetic
  logic [LW-1:0] prec8, nd8, zeros8, total8, w8, pad8, len8, lead8, sgn8;

  logic out_free;

  idec_digit_chain u_chain (
    .clk_i       (clk_i),
    .op_i        (cell_op),
    .bit_i       (mag_q[idec_pkg::VALUE_W-1]),
    .top_digit_o (top_digit)
  );

  // truncate and extend per length modifier and mode
  always_comb begin
    unique case (length_sel_i)
      idec_pkg::LSEL_SHORT: ext_val = (mode_i == idec_pkg::MODE_SIGNED) ?
                                      {{48{value_i[15]}}, value_i[15:0]} :
                                      {48'd0, value_i[15:0]};
      idec_pkg::LSEL_LONG:  ext_val = value_i;
      default:              ext_val = (mode_i == idec_pkg::MODE_SIGNED) ?
                                      {{32{value_i[31]}}, value_i[31:0]} :
                                      {32'd0, value_i[31:0]};
    endcase
    neg    = (mode_i == idec_pkg::MODE_SIGNED) && ext_val[63];
    in_mag = neg ? (64'd0 - ext_val) : ext_val;
  end

  // layout: lead pad, sign, zeros, digits, trailing pad
  always_comb begin
    prec8  = {2'b00, prec_q};
    nd8    = {3'b000, ndig_q};
    sgn8   = {7'd0, has_sign_q};
    zeros8 = (has_prec_q && (prec8 > nd8)) ? prec8 - nd8 : '0;
    total8 = sgn8 + zeros8 + nd8;
    w8     = {2'b00, width_q};
    pad8   = (w8 > total8) ? w8 - total8 : '0;
    len8   = total8 + pad8;
    lead8  = left_q ? '0 : pad8;
  end

  assign out_free = !out_valid_q || out_ready_i;

  // sequencer: next state, row control and output register load
  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    cnt_d       = cnt_q;
    sign_d      = sign_q;
    has_sign_d  = has_sign_q;
    left_d      = left_q;
    width_d     = width_q;
    has_prec_d  = has_prec_q;
    prec_d      = prec_q;
    ndig_d      = ndig_q;
    b1_d        = b1_q;
    b2_d        = b2_q;
    b3_d        = b3_q;
    b4_d        = b4_q;
    n_d         = n_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    cell_op     = idec_pkg::CELL_HOLD;
    in_ready_o  = 1'b0;

    unique case (state_q)
      idec_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cell_op    = idec_pkg::CELL_CLEAR;
          mag_d      = in_mag;
          cnt_d      = '0;
          left_d     = left_justify_i;
          width_d    = field_width_i;
          has_prec_d = precision_given_i;
          prec_d     = min_digits_i;
          has_sign_d = 1'b0;
          sign_d     = idec_pkg::CHAR_SPACE;
          if (mode_i == idec_pkg::MODE_SIGNED) begin
            priority if (neg) begin
              has_sign_d = 1'b1;
              sign_d     = idec_pkg::CHAR_MINUS;
            end else if (plus_sign_i) begin
              has_sign_d = 1'b1;
              sign_d     = idec_pkg::CHAR_PLUS;
            end else if (space_sign_i) begin
              has_sign_d = 1'b1;
              sign_d     = idec_pkg::CHAR_SPACE;
            end else begin
              has_sign_d = 1'b0;
            end
          end
          state_d = idec_pkg::ST_CONV;
        end
      end

      // one argument bit per cycle into the digit row
      idec_pkg::ST_CONV: begin
        cell_op = idec_pkg::CELL_CONV;
        mag_d   = {mag_q[idec_pkg::VALUE_W-2:0], 1'b0};
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          ndig_d  = NumDigits;
          state_d = idec_pkg::ST_NORM;
        end
      end

      // drop leading zero digits, keep at least one unless the value is zero with precision zero
      idec_pkg::ST_NORM: begin
        if ((ndig_q == 5'd1) || (top_digit != '0)) begin
          if ((top_digit == '0) && has_prec_q && (prec_q == '0)) begin
            ndig_d = '0;
          end
          state_d = idec_pkg::ST_SETUP;
        end else begin
          cell_op = idec_pkg::CELL_SHIFT;
          ndig_d  = ndig_q - 1'b1;
        end
      end

      // region boundaries and emitted length
      idec_pkg::ST_SETUP: begin
        b1_d = lead8;
        b2_d = lead8 + sgn8;
        b3_d = lead8 + sgn8 + zeros8;
        b4_d = lead8 + total8;
        n_d  = (len8 > MaxLen) ? MaxLen : len8;
        k_d  = '0;
        state_d = (len8 == '0) ? idec_pkg::ST_IDLE : idec_pkg::ST_EMIT;
      end

      // one character per cycle while the output register is free
      idec_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = (k_q + 1'b1) == n_q;
          priority if (k_q < b1_q) begin
            out_char_d = idec_pkg::CHAR_SPACE;
          end else if (k_q < b2_q) begin
            out_char_d = sign_q;
          end else if (k_q < b3_q) begin
            out_char_d = idec_pkg::CHAR_ZERO;
          end else if (k_q < b4_q) begin
            out_char_d = idec_pkg::CHAR_ZERO | {4'd0, top_digit};
            cell_op    = idec_pkg::CELL_SHIFT;
          end else begin
            out_char_d = idec_pkg::CHAR_SPACE;
          end
          k_d = k_q + 1'b1;
          if ((k_q + 1'b1) == n_q) begin
            state_d = idec_pkg::ST_IDLE;
          end
        end
      end

      default: state_d = idec_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= idec_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    cnt_q      <= cnt_d;
    sign_q     <= sign_d;
    has_sign_q <= has_sign_d;
    left_q     <= left_d;
    width_q    <= width_d;
    has_prec_q <= has_prec_d;
    prec_q     <= prec_d;
    ndig_q     <= ndig_d;
    b1_q       <= b1_d;
    b2_q       <= b2_d;
    b3_q       <= b3_d;
    b4_q       <= b4_d;
    n_q        <= n_d;
    k_q        <= k_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign character_o = out_char_q;
  assign last_o      = out_last_q;

endmodule
